[src/assert_macros.svh]
// Assertion macros for the vertex transform RTL, used by its top module.
// Simulation builds get checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define HVT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// Checked on every clock edge, reset included.
`define HVT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define HVT_ASSERT(lbl, prop, msg)
`define HVT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/hvt_pkg.sv]
// Shared constants and types for the homogeneous vertex transform.
// No dependencies; used by every module of the block.
package hvt_pkg;

    localparam int DIM       = 4;
    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int SHR_W     = SUM_W - FRAC_W;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int VEC_W     = DIM * WORD_W;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

    // Identity matrix: diagonal entry 1.0 in Q16.16
    localparam logic [CFG_W-1:0] COEF_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    typedef logic [DIM-1:0][WORD_W-1:0] t_vec;

    // Load enables of the three lane stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

[src/homogeneous_vertex_transform.sv]
// Homogeneous vertex transform: (x, y, z, h) row vector times a 4x4 Q16.16 matrix.
// Throughput: one beat per cycle while the output is not stalled by i_m_tready.
// Four column lanes each run four multipliers.
// Stages: multiply, pairwise add, final add with shift and clip, output register.
// Reset (synchronous, active low) empties the pipeline and loads the identity matrix.
`include "assert_macros.svh"

module homogeneous_vertex_transform
    import hvt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [VEC_W-1:0]     i_s_tdata,   // in_x, in_y, in_z, in_h
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [VEC_W-1:0]     o_m_tdata,   // out_x, out_y, out_z, out_h
    output logic                 o_m_tuser    // saturated
);

    logic [CFG_W-1:0] r_coef [NUM_REGS];
    logic             r_v1;
    logic             r_v2;
    logic             r_v3;

    t_stage_en        w_en;
    logic             w_go;
    t_vec             w_vec;
    t_vec             w_coef [DIM];
    t_vec             w_res;
    logic [DIM-1:0]   w_sat;
    logic             w_clip_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_coef[k] <= COEF_RESET[k];
            end
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    // A stage loads when it is empty or its contents move on this cycle
    assign w_en.s3    = !r_v3 || w_go;
    assign w_en.s2    = !r_v2 || !r_v3 || w_go;
    assign w_en.s1    = !r_v1 || !r_v2 || !r_v3 || w_go;
    assign o_s_tready = w_en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en.s1) r_v1 <= i_s_tvalid;
            if (w_en.s2) r_v2 <= r_v1;
            if (w_en.s3) r_v3 <= r_v2;
        end
    end

    assign w_vec = i_s_tdata;

    // Column j of row i: register 2*i + j/2, low half for even j
    for (genvar j = 0; j < DIM; j++) begin : g_lane
        for (genvar i = 0; i < DIM; i++) begin : g_row
            assign w_coef[j][i] = r_coef[2*i + j/2][(j%2)*WORD_W +: WORD_W];
        end

        hvt_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_vec  (w_vec),
            .i_coef (w_coef[j]),
            .o_res  (w_res[j]),
            .o_sat  (w_sat[j])
        );
    end

    hvt_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v3),
        .i_res      (w_res),
        .i_sat      (w_sat),
        .i_m_tready (i_m_tready),
        .o_load     (w_go),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Some component sits at a clip limit
    always_comb begin
        w_clip_seen = 1'b0;
        for (int j = 0; j < DIM; j++) begin
            if (o_m_tdata[j*WORD_W +: WORD_W] == WORD_MAX ||
                o_m_tdata[j*WORD_W +: WORD_W] == WORD_MIN) begin
                w_clip_seen = 1'b1;
            end
        end
    end

    `HVT_ASSERT_ALWAYS(a_rst_flush, !i_rst_n |=> !r_v1 && !r_v2 && !r_v3 && !o_m_tvalid,
        "reset left a beat in flight")
    `HVT_ASSERT(a_accept_enters, i_s_tvalid && o_s_tready |=> r_v1,
        "accepted beat lost at stage one")
    `HVT_ASSERT(a_stall_keeps, r_v3 && o_m_tvalid && !i_m_tready |=> r_v3 && o_m_tvalid,
        "beat dropped during stall")
    `HVT_ASSERT(a_sat_clipped, o_m_tvalid && o_m_tuser |-> w_clip_seen,
        "saturated flag without a clipped component")

endmodule

[src/hvt_lane.sv]
// One output column: four products, a two-level adder tree, shift and clip.
// Depends on hvt_pkg.
module hvt_lane
    import hvt_pkg::*;
(
    input  logic              i_clk,
    input  t_stage_en         i_en,
    input  t_vec              i_vec,
    input  t_vec              i_coef,
    output logic [WORD_W-1:0] o_res,
    output logic              o_sat
);

    logic signed [PROD_W-1:0] r_prod [DIM];
    logic signed [PAIR_W-1:0] r_pair [2];
    logic [WORD_W-1:0]        r_res;
    logic                     r_sat;

    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SHR_W-1:0]  w_shr;
    logic                     w_pos_ovf;
    logic                     w_neg_ovf;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int i = 0; i < DIM; i++) begin
                r_prod[i] <= $signed(i_vec[i]) * $signed(i_coef[i]);
            end
        end
        if (i_en.s2) begin
            r_pair[0] <= PAIR_W'(r_prod[0]) + PAIR_W'(r_prod[1]);
            r_pair[1] <= PAIR_W'(r_prod[2]) + PAIR_W'(r_prod[3]);
        end
        if (i_en.s3) begin
            r_res <= w_pos_ovf ? WORD_MAX :
                     w_neg_ovf ? WORD_MIN : w_shr[WORD_W-1:0];
            r_sat <= w_pos_ovf | w_neg_ovf;
        end
    end

    // Exact sum, then floor divide by 2^16 by dropping the fraction bits
    assign w_sum = SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]);
    assign w_shr = w_sum[SUM_W-1:FRAC_W];

    // Out of range when the bits above the word are not a sign extension
    assign w_pos_ovf = !w_shr[SHR_W-1] && (|w_shr[SHR_W-2:WORD_W-1]);
    assign w_neg_ovf = w_shr[SHR_W-1] && !(&w_shr[SHR_W-2:WORD_W-1]);

    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

[src/hvt_merge.sv]
// Merge stage: gathers the lane results into one beat and ORs the clip flags.
// Depends on hvt_pkg; fed by the hvt_lane instances.
module hvt_merge
    import hvt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_vec  i_res,
    input  logic  [DIM-1:0] i_sat,
    input  logic  i_m_tready,
    output logic  o_load,
    output logic  o_m_tvalid,
    output logic  [VEC_W-1:0] o_m_tdata,  // out_x, out_y, out_z, out_h
    output logic  o_m_tuser               // saturated
);

    logic             r_vld;
    logic [VEC_W-1:0] r_data;
    logic             r_sat;

    // Take a new beat when empty or when the held one leaves this cycle
    assign o_load = !r_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_load) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_data <= i_res;
            r_sat  <= |i_sat;
        end
    end

    assign o_m_tvalid = r_vld;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_sat;

endmodule
